/* design/bmba_pkg.sv */
// shared constants, types and the id helper function of the byte-map block allocator
package bmba_pkg;

  localparam int MAX_BLOCKS = 256;
  localparam int ADDR_W     = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = ADDR_W + 1;
  localparam int ID_W       = 8;
  localparam int SHIFT_W    = 4;
  localparam int COUNT_W    = 9;
  localparam int BYTES_W    = 21;
  localparam int OFF_W      = 20;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;
  localparam int FB_W       = 22;

  localparam logic [SHIFT_W-1:0] SHIFT_MIN = 4'd4;
  localparam logic [SHIFT_W-1:0] SHIFT_MAX = 4'd12;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_ALLOC = 2'd2;

  localparam logic CMD_FREE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 1'b1;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_DECIDE, OP_SCAN_RD, OP_SCAN_CHK, OP_LEFT_RD, OP_LEFT_CHK,
    OP_RIGHT_RD, OP_RIGHT_CHK, OP_WRITE, OP_ALLOC_DONE, OP_FREE_RD, OP_FREE_CHK,
    OP_FREE_DONE
  } op_t;

  typedef struct packed {
    op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic is_free;
    logic start_ok;
    logic hit;
    logic phase_end;
    logic wrap_ok;
    logic take;
    logic first;
    logic more;
    logic write_last;
  } dp_stat_t;

  function automatic logic [ID_W-1:0] pick_id(input logic [ID_W-1:0] left,
                                              input logic [ID_W-1:0] right);
    logic [ID_W-1:0] c;
    c = left + 1'b1;
    for (int k = 0; k < 3; k++) begin
      if (c == right || c == '0) c = c + 1'b1;
    end
    return c;
  endfunction

endpackage

/* design/bmba_in_if.sv */
// request channel: command beat with valid/ready
interface bmba_in_if;
  logic                          valid;
  logic                          ready;
  logic                          cmd;
  logic [bmba_pkg::BYTES_W-1:0]  alloc_bytes;
  logic [bmba_pkg::OFF_W-1:0]    free_offset;
  modport source (output valid, cmd, alloc_bytes, free_offset, input ready);
  modport sink (input valid, cmd, alloc_bytes, free_offset, output ready);
endinterface

/* design/bmba_out_if.sv */
// response channel: result beat with valid/ready
interface bmba_out_if;
  logic                          valid;
  logic                          ready;
  logic [bmba_pkg::STATUS_W-1:0] status;
  logic [bmba_pkg::OFF_W-1:0]    run_offset;
  logic [bmba_pkg::COUNT_W-1:0]  run_blocks;
  logic [bmba_pkg::COUNT_W-1:0]  blocks_used;
  modport source (output valid, status, run_offset, run_blocks, blocks_used, input ready);
  modport sink (input valid, status, run_offset, run_blocks, blocks_used, output ready);
endinterface

/* design/byte_map_block_allocator_core.sv */
// top level of the byte-map block allocator: one command beat in, one result beat out
// the owner map has one read port, so every block visited costs a read state
// and a check state
// one command at a time; a new beat is taken once the result beat has been taken
// rst (synchronous) clears the owner map valid bits at once, so all blocks read free
module byte_map_block_allocator_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [bmba_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [bmba_pkg::CFG_DATA_W-1:0]  cfg_data,
  bmba_in_if.sink                          in_ch,
  bmba_out_if.source                       out_ch
);
  bmba_pkg::dp_cmd_t            ctl;
  bmba_pkg::dp_stat_t           stat;
  logic                         rd_en;
  logic [bmba_pkg::ADDR_W-1:0]  rd_addr;
  logic                         wr_en;
  logic [bmba_pkg::ADDR_W-1:0]  wr_addr;
  logic [bmba_pkg::ID_W-1:0]    wr_data;
  logic [bmba_pkg::ID_W-1:0]    rd_data;

  bmba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  bmba_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_idx     (cfg_idx),
    .cfg_data    (cfg_data),
    .in_cmd      (in_ch.cmd),
    .in_bytes    (in_ch.alloc_bytes),
    .in_offset   (in_ch.free_offset),
    .ctl         (ctl),
    .stat        (stat),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .rd_data     (rd_data),
    .status      (out_ch.status),
    .run_offset  (out_ch.run_offset),
    .run_blocks  (out_ch.run_blocks),
    .blocks_used (out_ch.blocks_used)
  );

  bmba_owner_map u_map (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );
endmodule

/* design/bmba_owner_map.sv */
// owner id memory with per-entry valid bits, registered read
module bmba_owner_map (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         rd_en,
  input  logic [bmba_pkg::ADDR_W-1:0]  rd_addr,
  input  logic                         wr_en,
  input  logic [bmba_pkg::ADDR_W-1:0]  wr_addr,
  input  logic [bmba_pkg::ID_W-1:0]    wr_data,
  output logic [bmba_pkg::ID_W-1:0]    rd_data
);
  logic [bmba_pkg::ID_W-1:0]       mem [bmba_pkg::MAX_BLOCKS];
  logic [bmba_pkg::MAX_BLOCKS-1:0] vld;
  logic [bmba_pkg::ID_W-1:0]       q;
  logic                            vld_q;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) begin
      q     <= mem[rd_addr];
      vld_q <= vld[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  assign rd_data = vld_q ? q : '0;
endmodule

/* design/bmba_datapath.sv */
// datapath: config registers, search counters, id choice and result registers
module bmba_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [bmba_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [bmba_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_cmd,
  input  logic [bmba_pkg::BYTES_W-1:0]     in_bytes,
  input  logic [bmba_pkg::OFF_W-1:0]       in_offset,
  input  bmba_pkg::dp_cmd_t                ctl,
  output bmba_pkg::dp_stat_t               stat,
  output logic                             rd_en,
  output logic [bmba_pkg::ADDR_W-1:0]      rd_addr,
  output logic                             wr_en,
  output logic [bmba_pkg::ADDR_W-1:0]      wr_addr,
  output logic [bmba_pkg::ID_W-1:0]        wr_data,
  input  logic [bmba_pkg::ID_W-1:0]        rd_data,
  output logic [bmba_pkg::STATUS_W-1:0]    status,
  output logic [bmba_pkg::OFF_W-1:0]       run_offset,
  output logic [bmba_pkg::COUNT_W-1:0]     run_blocks,
  output logic [bmba_pkg::COUNT_W-1:0]     blocks_used
);
  localparam int CW = bmba_pkg::CNT_W;

  logic [bmba_pkg::SHIFT_W-1:0]  shift_cfg;
  logic [bmba_pkg::COUNT_W-1:0]  count_cfg;
  logic                          op_free;
  logic [bmba_pkg::BYTES_W-1:0]  bytes;
  logic [bmba_pkg::OFF_W-1:0]    foff;
  logic [CW-1:0]                 need;
  logic [CW-1:0]                 start;
  logic [CW-1:0]                 pos;
  logic [CW-1:0]                 runlen;
  logic [CW-1:0]                 x;
  logic                          phase;
  logic [bmba_pkg::ID_W-1:0]     id;
  logic [bmba_pkg::ID_W-1:0]     left;
  logic [bmba_pkg::ADDR_W-1:0]   mark;
  logic [CW-1:0]                 used;
  logic [bmba_pkg::STATUS_W-1:0] status_q;
  logic [bmba_pkg::OFF_W-1:0]    roff_q;
  logic [CW-1:0]                 rblk_q;

  logic [bmba_pkg::SHIFT_W-1:0]  sh;
  logic [CW-1:0]                 cnt;
  logic [bmba_pkg::FB_W-1:0]     free_bytes;
  logic [bmba_pkg::FB_W-1:0]     need_w;
  logic                          space_ok;
  logic [CW:0]                   mark_inc;
  logic [CW-1:0]                 start_c;
  logic [bmba_pkg::OFF_W-1:0]    bi;
  logic                          bi_ok;
  logic                          data_zero;
  logic [CW-1:0]                 run_inc;
  logic [CW:0]                   lim_sn;
  logic [CW:0]                   last;
  logic [CW:0]                   xe;
  logic                          xe_in;
  logic [CW:0]                   xn;
  logic [bmba_pkg::ID_W-1:0]     right;

  always_comb begin
    if (shift_cfg < bmba_pkg::SHIFT_MIN) sh = bmba_pkg::SHIFT_MIN;
    else if (shift_cfg > bmba_pkg::SHIFT_MAX) sh = bmba_pkg::SHIFT_MAX;
    else sh = shift_cfg;
    if (count_cfg == '0) cnt = CW'(1);
    else if (int'(count_cfg) > bmba_pkg::MAX_BLOCKS) cnt = CW'(bmba_pkg::MAX_BLOCKS);
    else cnt = CW'(count_cfg);
  end

  assign free_bytes = (used >= cnt) ? '0 : (bmba_pkg::FB_W'(cnt - used) << sh);
  assign need_w     = (bmba_pkg::FB_W'(bytes) + ((bmba_pkg::FB_W'(1) << sh) - 1'b1)) >> sh;
  assign space_ok   = (bytes != '0) && (free_bytes >= bmba_pkg::FB_W'(bytes));
  assign mark_inc   = (CW+1)'(mark) + 1'b1;
  assign start_c    = (mark_inc >= (CW+1)'(cnt)) ? '0 : CW'(mark_inc);
  assign bi         = foff >> sh;
  assign bi_ok      = bi < bmba_pkg::OFF_W'(cnt);
  assign data_zero  = rd_data == '0;
  assign run_inc    = runlen + 1'b1;
  assign lim_sn     = (CW+1)'(start) + (CW+1)'(need) - 2'd2;
  assign last       = (phase && lim_sn < (CW+1)'(cnt - 1'b1)) ? lim_sn
                                                               : (CW+1)'(cnt - 1'b1);
  assign xe         = (CW+1)'(x) + (CW+1)'(need);
  assign xe_in      = xe < (CW+1)'(cnt);
  assign xn         = (CW+1)'(pos) + 1'b1;
  assign right      = xe_in ? rd_data : '0;

  always_comb begin
    stat.is_free    = op_free;
    stat.start_ok   = op_free ? bi_ok : space_ok;
    stat.hit        = data_zero && (run_inc == need);
    stat.phase_end  = (CW+1)'(pos) == last;
    stat.wrap_ok    = !phase && (start != '0);
    stat.first      = rblk_q == '0;
    stat.take       = (rblk_q == '0) ? !data_zero : (rd_data == id);
    stat.more       = xn < (CW+1)'(cnt);
    stat.write_last = run_inc == need;
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = pos[bmba_pkg::ADDR_W-1:0];
    wr_en   = 1'b0;
    wr_addr = pos[bmba_pkg::ADDR_W-1:0];
    wr_data = id;
    unique case (ctl.op)
      bmba_pkg::OP_SCAN_RD, bmba_pkg::OP_FREE_RD: rd_en = 1'b1;
      bmba_pkg::OP_LEFT_RD: begin
        rd_en   = x != '0;
        rd_addr = bmba_pkg::ADDR_W'(x - 1'b1);
      end
      bmba_pkg::OP_RIGHT_RD: begin
        rd_en   = xe_in;
        rd_addr = bmba_pkg::ADDR_W'(xe);
      end
      bmba_pkg::OP_WRITE: wr_en = 1'b1;
      bmba_pkg::OP_FREE_CHK: begin
        wr_en   = stat.take;
        wr_data = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_cfg <= bmba_pkg::SHIFT_MIN;
      count_cfg <= bmba_pkg::COUNT_W'(bmba_pkg::MAX_BLOCKS);
      mark      <= bmba_pkg::ADDR_W'(bmba_pkg::MAX_BLOCKS - 1);
      used      <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          bmba_pkg::CFG_SHIFT: shift_cfg <= cfg_data[bmba_pkg::SHIFT_W-1:0];
          bmba_pkg::CFG_COUNT: count_cfg <= cfg_data[bmba_pkg::COUNT_W-1:0];
          default: ;
        endcase
      end
      if (ctl.op == bmba_pkg::OP_ALLOC_DONE) begin
        mark <= (xe >= (CW+1)'(2)) ? bmba_pkg::ADDR_W'(xe - 2'd2)
                                   : bmba_pkg::ADDR_W'(cnt - 1'b1);
        used <= used + need;
      end
      if (ctl.op == bmba_pkg::OP_FREE_DONE) begin
        used <= (used >= rblk_q) ? used - rblk_q : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctl.op)
      bmba_pkg::OP_LOAD: begin
        op_free <= in_cmd == bmba_pkg::CMD_FREE;
        bytes   <= in_bytes;
        foff    <= in_offset;
      end
      bmba_pkg::OP_DECIDE: begin
        need     <= CW'(need_w);
        start    <= start_c;
        pos      <= op_free ? CW'(bi) : start_c;
        runlen   <= '0;
        phase    <= 1'b0;
        status_q <= op_free ? bmba_pkg::ST_NOT_ALLOC : bmba_pkg::ST_NO_SPACE;
        roff_q   <= '0;
        rblk_q   <= '0;
      end
      bmba_pkg::OP_SCAN_CHK: begin
        if (stat.hit) begin
          x <= run_inc == need ? pos + 1'b1 - need : pos;
        end else if (stat.phase_end) begin
          phase  <= 1'b1;
          pos    <= '0;
          runlen <= '0;
        end else begin
          pos    <= pos + 1'b1;
          runlen <= data_zero ? run_inc : '0;
        end
      end
      bmba_pkg::OP_LEFT_CHK: left <= (x == '0) ? '0 : rd_data;
      bmba_pkg::OP_RIGHT_CHK: begin
        id     <= bmba_pkg::pick_id(left, right);
        pos    <= x;
        runlen <= '0;
      end
      bmba_pkg::OP_WRITE: begin
        pos    <= pos + 1'b1;
        runlen <= run_inc;
      end
      bmba_pkg::OP_ALLOC_DONE: begin
        status_q <= bmba_pkg::ST_OK;
        roff_q   <= bmba_pkg::OFF_W'(x) << sh;
        rblk_q   <= need;
      end
      bmba_pkg::OP_FREE_CHK: begin
        if (stat.take) begin
          if (stat.first) id <= rd_data;
          rblk_q <= rblk_q + 1'b1;
          pos    <= pos + 1'b1;
        end
      end
      bmba_pkg::OP_FREE_DONE: status_q <= bmba_pkg::ST_OK;
      default: ;
    endcase
  end

  assign status      = status_q;
  assign run_offset  = roff_q;
  assign run_blocks  = bmba_pkg::COUNT_W'(rblk_q);
  assign blocks_used = bmba_pkg::COUNT_W'(used);
endmodule

/* design/bmba_ctrl.sv */
// controller state machine: sequences the search, write and free sweeps
module bmba_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  bmba_pkg::dp_stat_t  stat,
  output bmba_pkg::dp_cmd_t   ctl
);
  typedef enum logic [13:0] {
    S_IDLE       = 14'b00000000000001,
    S_DECIDE     = 14'b00000000000010,
    S_SCAN_RD    = 14'b00000000000100,
    S_SCAN_CHK   = 14'b00000000001000,
    S_LEFT_RD    = 14'b00000000010000,
    S_LEFT_CHK   = 14'b00000000100000,
    S_RIGHT_RD   = 14'b00000001000000,
    S_RIGHT_CHK  = 14'b00000010000000,
    S_WRITE      = 14'b00000100000000,
    S_ALLOC_DONE = 14'b00001000000000,
    S_FREE_RD    = 14'b00010000000000,
    S_FREE_CHK   = 14'b00100000000000,
    S_FREE_DONE  = 14'b01000000000000,
    S_DONE       = 14'b10000000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  assign in_ready  = state == S_IDLE;
  assign out_valid = state == S_DONE;

  always_comb begin
    state_next = state;
    ctl.op     = bmba_pkg::OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.op     = bmba_pkg::OP_LOAD;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        ctl.op = bmba_pkg::OP_DECIDE;
        priority if (!stat.start_ok) state_next = S_DONE;
        else if (stat.is_free) state_next = S_FREE_RD;
        else state_next = S_SCAN_RD;
      end
      S_SCAN_RD: begin
        ctl.op     = bmba_pkg::OP_SCAN_RD;
        state_next = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        ctl.op = bmba_pkg::OP_SCAN_CHK;
        priority if (stat.hit) state_next = S_LEFT_RD;
        else if (stat.phase_end && stat.wrap_ok) state_next = S_SCAN_RD;
        else if (stat.phase_end) state_next = S_DONE;
        else state_next = S_SCAN_RD;
      end
      S_LEFT_RD: begin
        ctl.op     = bmba_pkg::OP_LEFT_RD;
        state_next = S_LEFT_CHK;
      end
      S_LEFT_CHK: begin
        ctl.op     = bmba_pkg::OP_LEFT_CHK;
        state_next = S_RIGHT_RD;
      end
      S_RIGHT_RD: begin
        ctl.op     = bmba_pkg::OP_RIGHT_RD;
        state_next = S_RIGHT_CHK;
      end
      S_RIGHT_CHK: begin
        ctl.op     = bmba_pkg::OP_RIGHT_CHK;
        state_next = S_WRITE;
      end
      S_WRITE: begin
        ctl.op = bmba_pkg::OP_WRITE;
        if (stat.write_last) state_next = S_ALLOC_DONE;
      end
      S_ALLOC_DONE: begin
        ctl.op     = bmba_pkg::OP_ALLOC_DONE;
        state_next = S_DONE;
      end
      S_FREE_RD: begin
        ctl.op     = bmba_pkg::OP_FREE_RD;
        state_next = S_FREE_CHK;
      end
      S_FREE_CHK: begin
        ctl.op = bmba_pkg::OP_FREE_CHK;
        priority if (stat.take && stat.more) state_next = S_FREE_RD;
        else if (stat.take) state_next = S_FREE_DONE;
        else if (stat.first) state_next = S_DONE;
        else state_next = S_FREE_DONE;
      end
      S_FREE_DONE: begin
        ctl.op     = bmba_pkg::OP_FREE_DONE;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
